[src/lrw_pkg.sv]
// Shared types, constants and the byte serializer function for the LCD
// rectangle window pixel streamer. Used by every module in src.
// No dependencies.
package lrw_pkg;

  localparam int COORD_W  = 16;
  localparam int DIM_W    = 11;
  localparam int OFFSET_W = 10;
  localparam int PIXEL_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int REQ_W    = 2;
  localparam int IDX_W    = 1;

  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 280;

  localparam logic [OFFSET_W-1:0] COLUMN_OFFSET_RESET = 10'd0;
  localparam logic [OFFSET_W-1:0] ROW_OFFSET_RESET    = 10'd20;

  // Depth of the job queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CMD_COLUMN_ADDR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_ROW_ADDR     = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_MEMORY_WRITE = 8'h2C;

  localparam logic [IDX_W-1:0] CFG_COLUMN_OFFSET = 1'b0;
  localparam logic [IDX_W-1:0] CFG_ROW_OFFSET    = 1'b1;

  localparam int BEAT_IDX_W = 4;
  localparam logic [BEAT_IDX_W-1:0] WINDOW_LAST_IDX = 4'd10;
  localparam logic [BEAT_IDX_W-1:0] PIXEL_LAST_IDX  = 4'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_FILL    = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_DRAW    = 2'd2,
    REQ_PIXEL   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_FILL = 2'd1,
    MODE_DRAW = 2'd2
  } mode_t;

  typedef enum logic {
    JOB_WINDOW = 1'b0,
    JOB_PIXEL  = 1'b1
  } job_kind_t;

  // A window job carries column start/end in w0/w1 and row start/end in w2/w3.
  // A pixel job carries the pixel in w0.
  typedef struct packed {
    job_kind_t            kind;
    logic [COORD_W-1:0]   w0;
    logic [COORD_W-1:0]   w1;
    logic [COORD_W-1:0]   w2;
    logic [COORD_W-1:0]   w3;
    logic                 last;
  } job_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_command;
    logic              last;
  } beat_t;

  function automatic logic [BEAT_IDX_W-1:0] job_final_idx(job_t job);
    return (job.kind == JOB_PIXEL) ? PIXEL_LAST_IDX : WINDOW_LAST_IDX;
  endfunction

  function automatic beat_t job_beat(job_t job, logic [BEAT_IDX_W-1:0] idx);
    beat_t b;
    b = '0;
    if (job.kind == JOB_PIXEL) begin
      if (idx == '0) begin
        b.data = job.w0[15:8];
      end else begin
        b.data = job.w0[7:0];
        b.last = job.last;
      end
    end else begin
      case (idx)
        4'd0:    begin b.data = CMD_COLUMN_ADDR; b.is_command = 1'b1; end
        4'd1:    b.data = job.w0[15:8];
        4'd2:    b.data = job.w0[7:0];
        4'd3:    b.data = job.w1[15:8];
        4'd4:    b.data = job.w1[7:0];
        4'd5:    begin b.data = CMD_ROW_ADDR; b.is_command = 1'b1; end
        4'd6:    b.data = job.w2[15:8];
        4'd7:    b.data = job.w2[7:0];
        4'd8:    b.data = job.w3[15:8];
        4'd9:    b.data = job.w3[7:0];
        4'd10:   begin b.data = CMD_MEMORY_WRITE; b.is_command = 1'b1; end
        default: b = '0;
      endcase
    end
    return b;
  endfunction

endpackage

[src/lrw_front.sv]
// Front end: accepts request beats, clips rectangles, tracks fill/draw
// progress and pushes window and pixel jobs into the queue. Uses lrw_pkg.
module lrw_front #(
  parameter int SCREEN_WIDTH  = lrw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = lrw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic [lrw_pkg::REQ_W-1:0]     in_req,
  input  logic [79:0]                   in_data,
  input  logic                          cfg_we,
  input  logic [lrw_pkg::IDX_W-1:0]     cfg_idx,
  input  logic [lrw_pkg::OFFSET_W-1:0]  cfg_value,
  output logic                          push,
  output lrw_pkg::job_t                 push_job
);

  localparam logic [16:0] SW_EXT = 17'(SCREEN_WIDTH);
  localparam logic [16:0] SH_EXT = 17'(SCREEN_HEIGHT);

  lrw_pkg::mode_t                 mode_r, mode_nxt;
  logic [lrw_pkg::PIXEL_W-1:0]    fill_colour_r, fill_colour_nxt;
  logic [lrw_pkg::DIM_W-1:0]      cw_r, cw_nxt;
  logic [lrw_pkg::DIM_W-1:0]      ch_r, ch_nxt;
  logic [lrw_pkg::COORD_W-1:0]    srl_r, srl_nxt;
  logic [lrw_pkg::COORD_W-1:0]    cc_r, cc_nxt;
  logic [lrw_pkg::DIM_W-1:0]      rc_r, rc_nxt;
  logic [lrw_pkg::OFFSET_W-1:0]   col_off_r, row_off_r;

  lrw_pkg::req_type_t  req;
  logic [15:0] x, y, w, h, pix;
  logic        rect_ok;
  logic [16:0] x_sum, y_sum, clip_w17, clip_h17;
  logic [15:0] col_start, col_end, row_start, row_end;
  logic [16:0] cc_inc17;
  logic [11:0] rc_inc12;
  logic        fill_last, fill_row_end, draw_in, draw_last, draw_row_end;

  assign req = lrw_pkg::req_type_t'(in_req);
  assign x   = in_data[15:0];
  assign y   = in_data[31:16];
  assign w   = in_data[47:32];
  assign h   = in_data[63:48];
  assign pix = in_data[79:64];

  assign rect_ok = (w != '0) && (h != '0) && ({1'b0, x} < SW_EXT) && ({1'b0, y} < SH_EXT);
  assign x_sum   = {1'b0, x} + {1'b0, w};
  assign y_sum   = {1'b0, y} + {1'b0, h};
  assign clip_w17 = (x_sum > SW_EXT) ? (SW_EXT - {1'b0, x}) : {1'b0, w};
  assign clip_h17 = (y_sum > SH_EXT) ? (SH_EXT - {1'b0, y}) : {1'b0, h};

  assign col_start = x + {6'b0, col_off_r};
  assign col_end   = x + clip_w17[15:0] - 16'd1 + {6'b0, col_off_r};
  assign row_start = y + {6'b0, row_off_r};
  assign row_end   = y + clip_h17[15:0] - 16'd1 + {6'b0, row_off_r};

  assign cc_inc17 = {1'b0, cc_r} + 17'd1;
  assign rc_inc12 = {1'b0, rc_r} + 12'd1;

  assign fill_row_end = cc_inc17 >= {6'b0, cw_r};
  assign fill_last    = fill_row_end && (rc_inc12 >= {1'b0, ch_r});
  assign draw_in      = (cc_r < {5'b0, cw_r}) && (rc_r < ch_r);
  assign draw_last    = (cc_inc17 == {6'b0, cw_r}) && (rc_inc12 == {1'b0, ch_r});
  // The column counter wraps at 16 bits; a wrap also ends the source row.
  assign draw_row_end = (cc_inc17[15:0] >= srl_r) || (cc_inc17[15:0] == '0);

  // Next-state logic.
  always_comb begin
    mode_nxt        = mode_r;
    fill_colour_nxt = fill_colour_r;
    cw_nxt          = cw_r;
    ch_nxt          = ch_r;
    srl_nxt         = srl_r;
    cc_nxt          = cc_r;
    rc_nxt          = rc_r;
    if (in_fire) begin
      case (req)
        lrw_pkg::REQ_FILL, lrw_pkg::REQ_DRAW: begin
          if (rect_ok) begin
            cw_nxt = clip_w17[lrw_pkg::DIM_W-1:0];
            ch_nxt = clip_h17[lrw_pkg::DIM_W-1:0];
            cc_nxt = '0;
            rc_nxt = '0;
            if (req == lrw_pkg::REQ_FILL) begin
              mode_nxt        = lrw_pkg::MODE_FILL;
              fill_colour_nxt = pix;
            end else begin
              mode_nxt = lrw_pkg::MODE_DRAW;
              srl_nxt  = w;
            end
          end
        end
        lrw_pkg::REQ_ADVANCE: begin
          if (mode_r == lrw_pkg::MODE_FILL) begin
            if (fill_last) begin
              mode_nxt = lrw_pkg::MODE_IDLE;
              cc_nxt   = '0;
              rc_nxt   = '0;
            end else if (fill_row_end) begin
              cc_nxt = '0;
              rc_nxt = rc_inc12[lrw_pkg::DIM_W-1:0];
            end else begin
              cc_nxt = cc_inc17[15:0];
            end
          end
        end
        lrw_pkg::REQ_PIXEL: begin
          if (mode_r == lrw_pkg::MODE_DRAW) begin
            if (draw_in && draw_last) begin
              mode_nxt = lrw_pkg::MODE_IDLE;
              cc_nxt   = '0;
              rc_nxt   = '0;
            end else if (draw_row_end) begin
              cc_nxt = '0;
              rc_nxt = rc_inc12[lrw_pkg::DIM_W-1:0];
            end else begin
              cc_nxt = cc_inc17[15:0];
            end
          end
        end
        default: mode_nxt = mode_r;
      endcase
    end
  end

  // Job generation.
  always_comb begin
    push          = 1'b0;
    push_job      = '0;
    push_job.kind = lrw_pkg::JOB_PIXEL;
    if (in_fire) begin
      case (req)
        lrw_pkg::REQ_FILL, lrw_pkg::REQ_DRAW: begin
          push          = rect_ok;
          push_job.kind = lrw_pkg::JOB_WINDOW;
          push_job.w0   = col_start;
          push_job.w1   = col_end;
          push_job.w2   = row_start;
          push_job.w3   = row_end;
        end
        lrw_pkg::REQ_ADVANCE: begin
          push          = (mode_r == lrw_pkg::MODE_FILL);
          push_job.w0   = fill_colour_r;
          push_job.last = fill_last;
        end
        lrw_pkg::REQ_PIXEL: begin
          push          = (mode_r == lrw_pkg::MODE_DRAW) && draw_in;
          push_job.w0   = pix;
          push_job.last = draw_last;
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= lrw_pkg::MODE_IDLE;
      fill_colour_r <= '0;
      cw_r          <= '0;
      ch_r          <= '0;
      srl_r         <= '0;
      cc_r          <= '0;
      rc_r          <= '0;
      col_off_r     <= lrw_pkg::COLUMN_OFFSET_RESET;
      row_off_r     <= lrw_pkg::ROW_OFFSET_RESET;
    end else begin
      mode_r        <= mode_nxt;
      fill_colour_r <= fill_colour_nxt;
      cw_r          <= cw_nxt;
      ch_r          <= ch_nxt;
      srl_r         <= srl_nxt;
      cc_r          <= cc_nxt;
      rc_r          <= rc_nxt;
      if (cfg_we) begin
        if (cfg_idx == lrw_pkg::CFG_COLUMN_OFFSET) begin
          col_off_r <= cfg_value;
        end else begin
          row_off_r <= cfg_value;
        end
      end
    end
  end

endmodule

[src/lrw_queue.sv]
// Small job FIFO that decouples the request front end from the byte
// serializer. Uses lrw_pkg for the job type and depth.
module lrw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lrw_pkg::job_t push_job,
  input  logic          pop,
  output lrw_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);

  localparam int PW = lrw_pkg::QUEUE_PTR_W;
  localparam int CW = lrw_pkg::QUEUE_CNT_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(lrw_pkg::QUEUE_DEPTH - 1);

  lrw_pkg::job_t  slot_r [lrw_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full     = (count_r == CW'(lrw_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[src/lrw_back.sv]
// Back end: takes jobs from the queue and serializes them one byte per beat
// into a registered output stage. Uses lrw_pkg.
module lrw_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lrw_pkg::job_t               head_job,
  input  logic                        empty,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lrw_pkg::BYTE_W-1:0]  out_tdata,
  output logic                        out_tuser,
  output logic                        out_tlast
);

  lrw_pkg::job_t                       job_r, job_nxt;
  logic                                busy_r, busy_nxt;
  logic [lrw_pkg::BEAT_IDX_W-1:0]      idx_r, idx_nxt;
  logic                                out_valid_r, out_valid_nxt;
  lrw_pkg::beat_t                      out_beat_r, out_beat_nxt;
  logic                                advance, at_final;

  assign advance  = busy_r && (!out_valid_r || out_tready);
  assign at_final = (idx_r == lrw_pkg::job_final_idx(job_r));
  // A new job is loaded in the same cycle the previous one sends its final
  // byte, so consecutive jobs stream without a gap.
  assign pop      = (!busy_r || (advance && at_final)) && !empty;

  always_comb begin
    job_nxt       = job_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_beat_nxt  = lrw_pkg::job_beat(job_r, idx_r);
      idx_nxt       = idx_r + 1'b1;
      if (at_final) begin
        busy_nxt = 1'b0;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      job_nxt  = head_job;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_beat_r.data;
  assign out_tuser  = out_beat_r.is_command;
  assign out_tlast  = out_beat_r.last;

endmodule

[src/lcd_rect_window_pixel_streamer_core.sv]
// A taken item goes through the job queue and job register into the registered output stage.
// Throughput: requests enter one per cycle while the four-entry job queue has room; the byte
// serializer sends one byte per cycle while out_tready is high; pixel 2 bytes, window 11.
// Reset: synchronous active-low rst_n; idle mode, counters cleared, column offset 0, row
// offset 20, queue and output stage empty.
// Depends on lrw_pkg, lrw_front, lrw_queue and lrw_back.
module lcd_rect_window_pixel_streamer_core #(
  parameter int SCREEN_WIDTH  = lrw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = lrw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // rect_x, rect_y, rect_width, rect_height, pixel_value (lowest bits first)
  input  logic [79:0]                   in_tdata,
  // req_type
  input  logic [lrw_pkg::REQ_W-1:0]     in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_byte
  output logic [lrw_pkg::BYTE_W-1:0]    out_tdata,
  // is_command
  output logic                          out_tuser,
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lrw_pkg::IDX_W-1:0]     cfg_index,
  input  logic [lrw_pkg::OFFSET_W-1:0]  cfg_data
);

  logic          push, pop, full, empty, in_fire;
  lrw_pkg::job_t push_job, head_job;

  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  lrw_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_req    (in_tuser),
    .in_data   (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_value (cfg_data),
    .push      (push),
    .push_job  (push_job)
  );

  lrw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (full),
    .empty    (empty)
  );

  lrw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[dv/lcd_window_byte_checker.sv]
`timescale 1ns / 100ps
// Monitor and predictor for the LCD rectangle window pixel streamer. It watches the
// request, result and register channels and checks every output byte in order.
// Depends on lrw_pkg for the request, mode and byte types.
module lcd_window_byte_checker #(
  parameter int SCREEN_W = lrw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_H = lrw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  // rect_x, rect_y, rect_width, rect_height, pixel_value (lowest bits first)
  input  logic [79:0]                   in_tdata,
  // req_type
  input  logic [lrw_pkg::REQ_W-1:0]     in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  // out_byte
  input  logic [lrw_pkg::BYTE_W-1:0]    out_tdata,
  // is_command
  input  logic                          out_tuser,
  input  logic                          out_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lrw_pkg::IDX_W-1:0]     cfg_index,
  input  logic [lrw_pkg::OFFSET_W-1:0]  cfg_data,
  output int                            mismatch_count,
  output int                            bytes_pending
);
  import lrw_pkg::*;

  mode_t                stream_mode;
  logic [PIXEL_W-1:0]   fill_colour;
  int unsigned          clip_w;
  int unsigned          clip_h;
  int unsigned          src_row_len;
  int unsigned          col_cnt;
  int unsigned          row_cnt;
  logic [OFFSET_W-1:0]  col_offset;
  logic [OFFSET_W-1:0]  row_offset;
  beat_t                expected_bytes[$];
  beat_t                want;

  assign bytes_pending = expected_bytes.size();

  task automatic expect_byte(logic [7:0] value, logic is_cmd, logic is_last);
    beat_t b;
    b.data       = value;
    b.is_command = is_cmd;
    b.last       = is_last;
    expected_bytes.push_back(b);
  endtask

  // Window coordinates go out big-endian.
  task automatic expect_word(int unsigned value);
    expect_byte(value[15:8], 1'b0, 1'b0);
    expect_byte(value[7:0], 1'b0, 1'b0);
  endtask

  task automatic expect_pixel(logic [15:0] value, logic is_last);
    expect_byte(value[15:8], 1'b0, 1'b0);
    expect_byte(value[7:0], 1'b0, is_last);
  endtask

  task automatic open_window(input int unsigned x, input int unsigned y,
                             input int unsigned w, input int unsigned h,
                             output bit accepted);
    accepted = 1'b0;
    if (w == 0 || h == 0 || x >= SCREEN_W || y >= SCREEN_H) return;
    if (x + w > SCREEN_W) w = SCREEN_W - x;
    if (y + h > SCREEN_H) h = SCREEN_H - y;
    clip_w  = w & 32'h7FF;
    clip_h  = h & 32'h7FF;
    col_cnt = 0;
    row_cnt = 0;
    expect_byte(CMD_COLUMN_ADDR, 1'b1, 1'b0);
    expect_word(x + col_offset);
    expect_word(x + w - 1 + col_offset);
    expect_byte(CMD_ROW_ADDR, 1'b1, 1'b0);
    expect_word(y + row_offset);
    expect_word(y + h - 1 + row_offset);
    expect_byte(CMD_MEMORY_WRITE, 1'b1, 1'b0);
    accepted = 1'b1;
  endtask

  task automatic predict_item(req_type_t kind, logic [79:0] fields);
    int unsigned x;
    int unsigned y;
    int unsigned w;
    int unsigned h;
    logic [15:0] pix;
    bit          accepted;
    bit          fin;
    x   = fields[15:0];
    y   = fields[31:16];
    w   = fields[47:32];
    h   = fields[63:48];
    pix = fields[79:64];
    case (kind)
      REQ_FILL: begin
        open_window(x, y, w, h, accepted);
        if (accepted) begin
          fill_colour = pix;
          stream_mode = MODE_FILL;
        end
      end
      REQ_DRAW: begin
        open_window(x, y, w, h, accepted);
        if (accepted) begin
          src_row_len = w;
          stream_mode = MODE_DRAW;
        end
      end
      REQ_ADVANCE: begin
        if (stream_mode == MODE_FILL) begin
          fin = (col_cnt + 1 >= clip_w) && (row_cnt + 1 >= clip_h);
          expect_pixel(fill_colour, fin);
          if (fin) begin
            stream_mode = MODE_IDLE;
            col_cnt     = 0;
            row_cnt     = 0;
          end else begin
            col_cnt++;
            if (col_cnt >= clip_w) begin
              col_cnt = 0;
              row_cnt = (row_cnt + 1) & 32'h7FF;
            end
          end
        end
      end
      default: begin
        if (stream_mode == MODE_DRAW) begin
          fin = 1'b0;
          // Source pixels outside the clipped window are counted but not sent.
          if (col_cnt < clip_w && row_cnt < clip_h) begin
            fin = (col_cnt + 1 == clip_w) && (row_cnt + 1 == clip_h);
            expect_pixel(pix, fin);
            if (fin) begin
              stream_mode = MODE_IDLE;
              col_cnt     = 0;
              row_cnt     = 0;
            end
          end
          if (!fin) begin
            col_cnt = (col_cnt + 1) & 32'hFFFF;
            if (col_cnt >= src_row_len || col_cnt == 0) begin
              col_cnt = 0;
              row_cnt = (row_cnt + 1) & 32'h7FF;
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stream_mode    = MODE_IDLE;
      fill_colour    = '0;
      clip_w         = 0;
      clip_h         = 0;
      src_row_len    = 0;
      col_cnt        = 0;
      row_cnt        = 0;
      col_offset     = COLUMN_OFFSET_RESET;
      row_offset     = ROW_OFFSET_RESET;
      mismatch_count = 0;
      expected_bytes.delete();
    end else begin
      // Results are checked before this edge's request is predicted, so a stray
      // byte can never be matched against a request taken in the same cycle.
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected beat: out_byte %h is_command %b last %b",
                 out_tdata, out_tuser, out_tlast);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte mismatch: expected %h, actual %h", want.data, out_tdata);
            mismatch_count++;
          end
          if (out_tuser !== want.is_command) begin
            $error("is_command mismatch: expected %b, actual %b", want.is_command, out_tuser);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last mismatch: expected %b, actual %b", want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COLUMN_OFFSET) col_offset = cfg_data;
        else                                row_offset = cfg_data;
      end
      if (in_tvalid && in_tready) predict_item(req_type_t'(in_tuser), in_tdata);
    end
  end

endmodule

[dv/lcd_rect_window_pixel_streamer_core_tb.sv]
`timescale 1ns / 100ps
// Top of the testbench for the LCD rectangle window pixel streamer: clock, reset,
// request and register stimulus, output back-pressure and the final verdict.
// Depends on lrw_pkg, the streamer core and lcd_window_byte_checker.
module lcd_rect_window_pixel_streamer_core_tb;
  import lrw_pkg::*;

  localparam int SCREEN_W    = SCREEN_WIDTH_DEF;
  localparam int SCREEN_H    = SCREEN_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 150;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [79:0]           in_tdata;
  logic [REQ_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [BYTE_W-1:0]     out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index;
  logic [OFFSET_W-1:0]   cfg_data;
  int                    mismatch_count;
  int                    bytes_pending;
  int                    cycle_count;
  int                    items_sent;
  int                    burst_left;
  bit                    hold_off_request;

  lcd_rect_window_pixel_streamer_core #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  lcd_window_byte_checker #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) checker_i (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatch_count, .bytes_pending
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [15:0] any16();
    return 16'($urandom_range(0, 65535));
  endfunction

  // Requests go out in bursts; between bursts the valid line may drop for a while.
  task automatic offer(req_type_t kind, logic [15:0] x, logic [15:0] y,
                       logic [15:0] w, logic [15:0] h, logic [15:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {pix, h, w, y, x};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Waits until every expected byte is out, plus a margin for requests with no output.
  task automatic settle();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_offset(logic [IDX_W-1:0] idx, logic [OFFSET_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly complete fill and draw transactions with random geometry, some cut
  // short or overrun, and a little noise.
  task automatic run_random_traffic(int target);
    int          first;
    int unsigned x;
    int unsigned y;
    int unsigned w;
    int unsigned h;
    int unsigned cw;
    int unsigned ch;
    int unsigned count;
    int          pick;
    int          twist;
    first = items_sent;
    while (items_sent - first < target) begin
      pick = $urandom_range(0, 9);
      if (pick >= 8) begin
        repeat ($urandom_range(1, 3))
          offer(req_type_t'($urandom_range(0, 3)), any16(), any16(), any16(), any16(), any16());
      end else begin
        case ($urandom_range(0, 4))
          0:       x = 0;
          1:       x = $urandom_range(SCREEN_W - 6, SCREEN_W - 1);
          default: x = $urandom_range(0, SCREEN_W - 1);
        endcase
        case ($urandom_range(0, 4))
          0:       y = 0;
          1:       y = $urandom_range(SCREEN_H - 6, SCREEN_H - 1);
          default: y = $urandom_range(0, SCREEN_H - 1);
        endcase
        w  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 65535) : $urandom_range(1, 6);
        h  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 65535) : $urandom_range(1, 6);
        cw = (x + w > SCREEN_W) ? SCREEN_W - x : w;
        ch = (y + h > SCREEN_H) ? SCREEN_H - y : h;
        // A fill needs one tick per pixel; a draw needs full source rows up to
        // the last visible pixel.
        count = (pick < 4) ? cw * ch : (ch - 1) * w + cw;
        if (count > 12) count = 12;
        twist = $urandom_range(0, 9);
        if (twist == 0)      count = $urandom_range(0, count - 1);
        else if (twist == 1) count = count + $urandom_range(1, 2);
        if (pick < 4) begin
          offer(REQ_FILL, x, y, w, h, any16());
          repeat (count) offer(REQ_ADVANCE, any16(), any16(), any16(), any16(), any16());
        end else begin
          offer(REQ_DRAW, x, y, w, h, any16());
          repeat (count) offer(REQ_PIXEL, any16(), any16(), any16(), any16(), any16());
        end
      end
    end
  endtask

  // Receiver back-pressure: styles change at random; on request it
  // holds off for a long stretch so the job queue fills and the input stalls.
  initial begin
    rx_style_t style;
    int        style_left;
    int        tick;
    style      = RX_ALWAYS;
    style_left = 0;
    tick       = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (style_left == 0) begin
          style      = rx_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(16, 80);
        end
        style_left--;
        tick++;
        case (style)
          RX_ALWAYS: out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= (tick % 4 == 0);
          default:   out_tready <= (tick % 4 != 0);
        endcase
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = REQ_FILL;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_COLUMN_OFFSET;
    cfg_data         = '0;
    cycle_count      = 0;
    items_sent       = 0;
    burst_left       = 0;
    hold_off_request = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Items in the wrong mode and rejected requests produce nothing.
    offer(REQ_ADVANCE, 16'd0, 16'd0, 16'd1, 16'd1, 16'h1111);
    offer(REQ_PIXEL,   16'd0, 16'd0, 16'd1, 16'd1, 16'h2222);
    offer(REQ_FILL,    16'd0, 16'd0, 16'd0, 16'd5, 16'h3333);
    offer(REQ_FILL,    16'd0, 16'd0, 16'd5, 16'd0, 16'h4444);
    offer(REQ_DRAW,    16'(SCREEN_W), 16'd0, 16'd1, 16'd1, 16'h0000);
    offer(REQ_DRAW,    16'd0, 16'(SCREEN_H), 16'd1, 16'd1, 16'h0000);
    offer(REQ_FILL,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Single pixel in the bottom-right corner, then a tick after it is done.
    offer(REQ_FILL,    16'(SCREEN_W - 1), 16'(SCREEN_H - 1), 16'd1, 16'd1, 16'hFFFF);
    offer(REQ_ADVANCE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer(REQ_ADVANCE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    // Whole screen, abandoned after two pixels by a draw that is clipped to 2x2.
    offer(REQ_FILL,    16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'h0000);
    offer(REQ_ADVANCE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    offer(REQ_PIXEL,   16'd0, 16'd0, 16'd0, 16'd0, 16'hBEEF);
    offer(REQ_ADVANCE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    offer(REQ_DRAW,    16'(SCREEN_W - 2), 16'(SCREEN_H - 2), 16'd4, 16'd3, 16'd0);
    offer(REQ_ADVANCE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    offer(REQ_PIXEL,   16'd0, 16'd0, 16'd0, 16'd0, 16'h0000);
    offer(REQ_PIXEL,   16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    offer(REQ_PIXEL,   16'd0, 16'd0, 16'd0, 16'd0, 16'hA5A5);
    offer(REQ_PIXEL,   16'd0, 16'd0, 16'd0, 16'd0, 16'h5A5A);
    offer(REQ_PIXEL,   16'd0, 16'd0, 16'd0, 16'd0, 16'h1234);
    offer(REQ_PIXEL,   16'd0, 16'd0, 16'd0, 16'd0, 16'h8001);
    // Source pixels after the final one are ignored.
    offer(REQ_PIXEL,   16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    offer(REQ_PIXEL,   16'd0, 16'd0, 16'd0, 16'd0, 16'h0000);
    offer(REQ_DRAW,    16'd0, 16'd0, 16'd1, 16'd1, 16'd0);
    offer(REQ_PIXEL,   16'd0, 16'd0, 16'd0, 16'd0, 16'hC3C3);

    // Long receiver stall while a fill keeps ticking.
    offer(REQ_FILL, 16'd0, 16'd0, 16'd5, 16'd6, any16());
    hold_off_request = 1'b1;
    repeat (20) offer(REQ_ADVANCE, any16(), any16(), any16(), any16(), any16());

    run_random_traffic(10);
    settle();
    write_offset(CFG_COLUMN_OFFSET, '1);
    write_offset(CFG_ROW_OFFSET, '1);
    run_random_traffic(10);
    settle();
    write_offset(CFG_COLUMN_OFFSET, '0);
    write_offset(CFG_ROW_OFFSET, '0);
    run_random_traffic(10);
    settle();
    write_offset(CFG_ROW_OFFSET, OFFSET_W'($urandom_range(0, 1023)));
    write_offset(CFG_COLUMN_OFFSET, OFFSET_W'($urandom_range(0, 1023)));
    run_random_traffic(10);
    settle();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
